/* rtl/core/sbcu_pkg.sv */
// Types and constants shared by the seven-bit continuation unpacker.
// No dependencies.
package sbcu_pkg;

  localparam int unsigned MaxFrameBytes = 256;
  localparam int unsigned CountW = 9;

  typedef enum logic [1:0] {
    KIND_FULL     = 2'd0,
    KIND_FINAL    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]        data;
    kind_t             kind;
    logic [3:0]        valid_bits;
    logic [CountW-1:0] count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [7:0]        acc;
    logic [2:0]        bits;
    logic [CountW-1:0] seen;
  } frame_state_t;

endpackage

/* rtl/core/sbcu_step.sv */
// Per-word decode: merges seven data bits into the accumulator and forms up to
// two results plus the next frame state. Uses sbcu_pkg.
module sbcu_step (
  input  logic [7:0]           coded_byte,
  input  sbcu_pkg::frame_state_t cur,
  output sbcu_pkg::frame_state_t nxt,
  output sbcu_pkg::result_t    res0,
  output sbcu_pkg::result_t    res1,
  output logic [1:0]           num_res
);
  import sbcu_pkg::*;

  logic [14:0]       merged;
  logic              more;
  logic              has_full;
  logic              overflow;
  logic              ends;
  logic [CountW-1:0] count;
  logic [7:0]        acc_new;
  logic [2:0]        bits_new;
  result_t           full_r;
  result_t           end_r;

  always_comb begin
    more     = coded_byte[7];
    count    = cur.seen + CountW'(1);
    merged   = {7'd0, cur.acc} | ({8'd0, coded_byte[6:0]} << cur.bits);
    has_full = (cur.bits != 3'd0);
    overflow = more && (count > CountW'(MaxFrameBytes));
    ends     = !more || overflow;

    if (has_full) begin
      acc_new  = {1'b0, merged[14:8]};
      bits_new = cur.bits - 3'd1;
    end else begin
      acc_new  = merged[7:0];
      bits_new = 3'd7;
    end

    full_r.data       = merged[7:0];
    full_r.kind       = KIND_FULL;
    full_r.valid_bits = 4'd8;
    full_r.count      = count;
    full_r.last       = !ends;

    if (!more) begin
      end_r.data       = acc_new;
      end_r.kind       = KIND_FINAL;
      end_r.valid_bits = {1'b0, bits_new};
    end else begin
      end_r.data       = 8'd0;
      end_r.kind       = KIND_OVERFLOW;
      end_r.valid_bits = 4'd0;
    end
    end_r.count = count;
    end_r.last  = 1'b1;

    if (has_full) begin
      res0 = full_r;
    end else begin
      res0 = end_r;
    end
    res1    = end_r;
    num_res = {1'b0, has_full} + {1'b0, ends};

    if (ends) begin
      nxt = '0;
    end else begin
      nxt.acc  = acc_new;
      nxt.bits = bits_new;
      nxt.seen = count;
    end
  end

endmodule

/* rtl/core/seven_bit_continuation_unpacker_top.sv */
// Seven-bit continuation unpacker, top level. Uses sbcu_pkg and sbcu_step.
// A result is registered and appears in the cycle after its coded word is accepted.
// Throughput: one word per cycle when it yields at most one result and the output
// is not stalled; a word that yields two holds off the next word until the single
// output port, draining a two-entry result buffer, pops the last entry.
// Reset (synchronous, rst high) clears the frame state and empties the buffer.
module seven_bit_continuation_unpacker_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] coded_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [1:0] result_kind,
  output logic [3:0] valid_bits,
  output logic [8:0] frame_byte_count,
  output logic       last_of_run
);
  import sbcu_pkg::*;

  frame_state_t state;
  frame_state_t state_next;
  result_t      res0;
  result_t      res1;
  logic [1:0]   num_res;
  result_t      slot0;
  result_t      slot1;
  logic [1:0]   fill;
  logic         take;
  logic         pop;

  sbcu_step u_step (
    .coded_byte (coded_byte),
    .cur        (state),
    .nxt        (state_next),
    .res0       (res0),
    .res1       (res1),
    .num_res    (num_res)
  );

  // accept only when the buffer is empty after this cycle's pop
  assign in_ready = (fill == 2'd0) || ((fill == 2'd1) && out_ready);
  assign take     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      fill  <= 2'd0;
    end else begin
      if (take) begin
        state <= state_next;
        fill  <= num_res;
      end else if (pop) begin
        fill  <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign out_valid        = (fill != 2'd0);
  assign data_byte        = slot0.data;
  assign result_kind      = slot0.kind;
  assign valid_bits       = slot0.valid_bits;
  assign frame_byte_count = slot0.count;
  assign last_of_run      = slot0.last;

endmodule

/* tb/sv/seven_bit_continuation_unpacker_top_test.sv */
// Self-checking testbench for seven_bit_continuation_unpacker_top.
// Predicts every result word from each accepted coded word and compares field by field.
// Depends on sbcu_pkg and the unpacker RTL.
module seven_bit_continuation_unpacker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbcu_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] coded_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic [1:0] result_kind;
  logic [3:0] valid_bits;
  logic [8:0] frame_byte_count;
  logic       last_of_run;

  // predictor state
  logic [7:0]        acc_q = 8'h00;
  logic [2:0]        nbits_q = 3'd0;
  logic [CountW-1:0] seen_q = '0;
  result_t           expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int results_checked = 0;
  int frames_closed = 0;
  int overflows_seen = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  seven_bit_continuation_unpacker_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .coded_byte       (coded_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_byte        (data_byte),
    .result_kind      (result_kind),
    .valid_bits       (valid_bits),
    .frame_byte_count (frame_byte_count),
    .last_of_run      (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void unpack_coded_word(input logic [7:0] w);
    logic              more;
    logic [2:0]        k;
    logic [CountW-1:0] cnt;
    logic [15:0]       merged;
    logic              has_full;
    logic              ends;
    result_t           r;
    more = w[7];
    k = nbits_q;
    cnt = seen_q + 9'd1;
    merged = {8'h00, acc_q} | ({9'd0, w[6:0]} << k);
    has_full = (k != 3'd0);
    if (has_full) begin
      acc_q = merged[15:8];
      nbits_q = k - 3'd1;
    end else begin
      acc_q = merged[7:0];
      nbits_q = k + 3'd7;
    end
    ends = !more || (cnt > MaxFrameBytes);
    if (has_full) begin
      r.data = merged[7:0];
      r.kind = KIND_FULL;
      r.valid_bits = 4'd8;
      r.count = cnt;
      r.last = !ends;
      expected_results.push_back(r);
    end
    if (!more) begin
      r.data = acc_q;
      r.kind = KIND_FINAL;
      r.valid_bits = {1'b0, nbits_q};
      r.count = cnt;
      r.last = 1'b1;
      expected_results.push_back(r);
      frames_closed++;
    end else if (cnt > MaxFrameBytes) begin
      r.data = 8'h00;
      r.kind = KIND_OVERFLOW;
      r.valid_bits = 4'd0;
      r.count = cnt;
      r.last = 1'b1;
      expected_results.push_back(r);
      overflows_seen++;
    end
    if (ends) begin
      acc_q = 8'h00;
      nbits_q = 3'd0;
      seen_q = '0;
    end else begin
      seen_q = cnt;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // input monitor feeds the predictor, then the output word is checked
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        unpack_coded_word(coded_byte);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: unexpected result word data=%h kind=%0d bits=%0d",
                     data_byte, result_kind, valid_bits);
            $display("       count=%0d last=%0b", frame_byte_count, last_of_run);
          end
        end else begin
          want = expected_results.pop_front();
          if (data_byte !== want.data || result_kind !== want.kind ||
              valid_bits !== want.valid_bits || frame_byte_count !== want.count ||
              last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: exp data=%h kind=%0d bits=%0d count=%0d last=%0b",
                       want.data, want.kind, want.valid_bits, want.count, want.last);
              $display("       got data=%h kind=%0d bits=%0d count=%0d last=%0b",
                       data_byte, result_kind, valid_bits, frame_byte_count, last_of_run);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                 StallLimit, expected_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // valid stays high from one word to the next unless an idle gap is taken
  task automatic send_word(input logic [7:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coded_byte <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_frame(input int len);
    logic [7:0] w;
    for (int i = 0; i < len; i++) begin
      w = 8'($urandom_range(0, 127));
      w[7] = (i != len - 1);
      send_word(w);
    end
  endtask

  task automatic test_short_frames();
    send_word(8'h00);
    send_word(8'h7F);
    send_word(8'h2A);
    send_word(8'hFF);
    send_word(8'h7F);
    send_word(8'h80);
    send_word(8'h00);
    send_word(8'hD5);
    send_word(8'hAA);
    send_word(8'h01);
  endtask

  // seven continuation words leave one pending bit, so the terminator fills
  // the accumulator exactly and the final word carries zero bits
  task automatic test_exact_fill();
    send_word(8'hFF);
    send_word(8'h80);
    send_word(8'hAA);
    send_word(8'hD5);
    send_word(8'hFF);
    send_word(8'h80);
    send_word(8'hFF);
    send_word(8'h7F);
  endtask

  task automatic test_overflow_frames();
    for (int i = 0; i <= MaxFrameBytes; i++) begin
      send_word(8'h80 | 8'($urandom_range(0, 127)));
    end
    send_frame(MaxFrameBytes + 1);
  endtask

  task automatic test_random_frames(input int n_words, input int s_idle, input int r_idle);
    int start;
    int pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_word(8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        send_frame($urandom_range(MaxFrameBytes - 6, MaxFrameBytes + 6));
      end else begin
        send_frame($urandom_range(1, 18));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 88;
    test_short_frames();
    test_exact_fill();
    test_overflow_frames();

    test_random_frames(300, 23, 88);
    test_random_frames(300, 88, 23);
    test_random_frames(300, 0, 0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("ERROR: %0d expected results never arrived", expected_results.size());
    end
    $display("Summary: %0d coded words in, %0d result words checked", words_sent,
             results_checked);
    $display("         %0d frames terminated, %0d overflow errors, %0d mismatches",
             frames_closed, overflows_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
